// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle
`define ASSERT_SAME(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("same-cycle assertion failed");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("next-cycle assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== design/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg
// Types and fixed field widths of the sparse set swap-remove unit.
// ----------------------------------------------------------------------------
package sss_pkg;

	// Field widths of the command and response channels
	localparam int FLD_ID_W   = 10;
	localparam int FLD_SLOT_W = 10;
	localparam int FLD_CNT_W  = 11;
	localparam int WORD_W     = 32;
	localparam int PAY_W      = 4 * WORD_W;

	// Command actions
	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	// Response status codes
	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear_step;
		logic ready;
		logic commit;
		logic move;
	} ctrl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_valid;
		logic clear_last;
		logic out_free;
		logic need_move;
	} stat_t;

endpackage

// ===== design/sss_cmd_if.sv =====
// ----------------------------------------------------------------------------
// sss_cmd_if
// Command channel: valid/ready handshake carrying one add or remove request.
// ----------------------------------------------------------------------------
interface sss_cmd_if;
	import sss_pkg::*;

	logic                valid;
	logic                ready;
	logic                action;
	logic [FLD_ID_W-1:0] entity_id;
	logic [WORD_W-1:0]   pos_x;
	logic [WORD_W-1:0]   pos_y;
	logic [WORD_W-1:0]   vel_x;
	logic [WORD_W-1:0]   vel_y;

	modport source (
		output valid, action, entity_id, pos_x, pos_y, vel_x, vel_y,
		input  ready
	);

	modport sink (
		input  valid, action, entity_id, pos_x, pos_y, vel_x, vel_y,
		output ready
	);

endinterface

// ===== design/sss_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sss_rsp_if
// Response channel: valid/ready handshake carrying one result per command.
// ----------------------------------------------------------------------------
interface sss_rsp_if;
	import sss_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	logic [FLD_SLOT_W-1:0] slot;
	logic                  moved;
	logic [FLD_ID_W-1:0]   moved_entity;
	logic [FLD_SLOT_W-1:0] moved_from_slot;
	logic [FLD_CNT_W-1:0]  live_count;

	modport source (
		output valid, status, slot, moved, moved_entity, moved_from_slot, live_count,
		input  ready
	);

	modport sink (
		input  valid, status, slot, moved, moved_entity, moved_from_slot, live_count,
		output ready
	);

endinterface

// ===== design/sss_ctrl.sv =====
// ----------------------------------------------------------------------------
// sss_ctrl
// Controller: sequences the sparse map clear, command lookup, commit and the
// second sparse map write of a swap-remove.
// ----------------------------------------------------------------------------
module sss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  sss_pkg::stat_t stat,
	output sss_pkg::ctrl_t ctrl
);
	import sss_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_MOVE
	} state_t;

	state_t state_q;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (stat.clear_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (stat.in_valid) state_q <= S_LOOKUP;
				end
				S_LOOKUP: begin
					if (stat.out_free) state_q <= stat.need_move ? S_MOVE : S_IDLE;
				end
				S_MOVE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// Decode datapath commands
	always_comb begin
		ctrl = '0;
		case (state_q)
			S_CLEAR:  ctrl.clear_step = 1'b1;
			S_IDLE:   ctrl.ready      = 1'b1;
			S_LOOKUP: ctrl.commit     = stat.out_free;
			S_MOVE:   ctrl.move       = 1'b1;
			default:  ctrl            = '0;
		endcase
	end

endmodule

// ===== design/sss_datapath.sv =====
// ----------------------------------------------------------------------------
// sss_datapath
// Datapath: sparse map, dense entity and payload memories, live count and
// the response register.
// ----------------------------------------------------------------------------
module sss_datapath #(
	parameter int ENTITY_IDS = 1024,
	parameter int CAPACITY   = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sss_pkg::ctrl_t ctrl,
	output sss_pkg::stat_t stat,
	sss_cmd_if.sink        cmd,
	sss_rsp_if.source      rsp
);
	import sss_pkg::*;

	localparam int EID_W  = $clog2(ENTITY_IDS);
	localparam int SIDX_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	// Memories: sparse map holds {valid, slot}
	logic [SIDX_W:0]    sparse_mem [ENTITY_IDS];
	logic [EID_W-1:0]   ent_mem    [CAPACITY];
	logic [PAY_W-1:0]   pay_mem    [CAPACITY];

	logic               capture;
	logic [CNT_W-1:0]   count_q;
	logic [EID_W-1:0]   clr_addr_q;

	// Captured command and read data
	logic               act_q;
	logic [EID_W-1:0]   idx_q;
	logic               id_ok_q;
	logic [PAY_W-1:0]   pay_q;
	logic [SIDX_W-1:0]  last_q;
	logic [SIDX_W:0]    sp_rd_q;
	logic [EID_W-1:0]   ent_rd_q;
	logic [PAY_W-1:0]   pay_rd_q;

	// Held for the second sparse map write
	logic [EID_W-1:0]   ment_q;
	logic [SIDX_W-1:0]  freed_q;

	// Response register
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [FLD_SLOT_W-1:0] out_slot_q;
	logic                  out_moved_q;
	logic [FLD_ID_W-1:0]   out_ment_q;
	logic [FLD_SLOT_W-1:0] out_from_q;
	logic [FLD_CNT_W-1:0]  out_live_q;

	logic [SIDX_W-1:0]  last_nx;
	logic               sp_valid;
	logic [SIDX_W-1:0]  sp_slot;
	status_t            res_status;
	logic [SIDX_W-1:0]  res_slot;
	logic               add_ok;
	logic               rem_ok;
	logic               do_move;
	logic [CNT_W-1:0]   count_nx;
	logic               out_free;

	logic               sp_we;
	logic [EID_W-1:0]   sp_wa;
	logic [SIDX_W:0]    sp_wd;

	assign capture   = cmd.valid & ctrl.ready;
	assign cmd.ready = ctrl.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign stat = '{
		in_valid:   cmd.valid,
		clear_last: (clr_addr_q == EID_W'(ENTITY_IDS - 1)),
		out_free:   out_free,
		need_move:  do_move
	};

	// Address of the last live slot
	assign last_nx = (count_q == '0) ? '0 : SIDX_W'(count_q - 1'b1);

	assign sp_valid = sp_rd_q[SIDX_W];
	assign sp_slot  = sp_rd_q[SIDX_W-1:0];

	// Decide the outcome from the lookup data
	always_comb begin
		res_status = ST_DONE;
		res_slot   = '0;
		add_ok     = 1'b0;
		rem_ok     = 1'b0;
		do_move    = 1'b0;
		if (act_q == ACT_ADD) begin
			if (!id_ok_q) begin
				res_status = ST_FULL;
			end else if (sp_valid) begin
				res_status = ST_PRESENT;
				res_slot   = sp_slot;
			end else if (count_q == CNT_W'(CAPACITY)) begin
				res_status = ST_FULL;
			end else begin
				add_ok   = 1'b1;
				res_slot = SIDX_W'(count_q);
			end
		end else begin
			if (!id_ok_q || !sp_valid || (count_q == '0)) begin
				res_status = ST_ABSENT;
			end else begin
				rem_ok   = 1'b1;
				res_slot = sp_slot;
				do_move  = (sp_slot < last_q);
			end
		end
	end

	always_comb begin
		count_nx = count_q;
		if (add_ok) count_nx = count_q + 1'b1;
		else if (rem_ok) count_nx = count_q - 1'b1;
	end

	// Select the sparse map write
	always_comb begin
		sp_we = 1'b0;
		sp_wa = clr_addr_q;
		sp_wd = '0;
		if (ctrl.clear_step) begin
			sp_we = 1'b1;
		end else if (ctrl.commit && add_ok) begin
			sp_we = 1'b1;
			sp_wa = idx_q;
			sp_wd = {1'b1, SIDX_W'(count_q)};
		end else if (ctrl.commit && rem_ok) begin
			sp_we = 1'b1;
			sp_wa = idx_q;
		end else if (ctrl.move) begin
			sp_we = 1'b1;
			sp_wa = ment_q;
			sp_wd = {1'b1, freed_q};
		end
	end

	// Sparse map
	always_ff @(posedge clk) begin
		if (sp_we) sparse_mem[sp_wa] <= sp_wd;
		if (capture) sp_rd_q <= sparse_mem[EID_W'(cmd.entity_id)];
	end

	// Dense entity and payload memories
	always_ff @(posedge clk) begin
		if (ctrl.commit && add_ok) begin
			ent_mem[SIDX_W'(count_q)] <= idx_q;
			pay_mem[SIDX_W'(count_q)] <= pay_q;
		end else if (ctrl.commit && do_move) begin
			ent_mem[sp_slot] <= ent_rd_q;
			pay_mem[sp_slot] <= pay_rd_q;
		end
		if (capture) begin
			ent_rd_q <= ent_mem[last_nx];
			pay_rd_q <= pay_mem[last_nx];
		end
	end

	// Capture the command and hold move operands
	always_ff @(posedge clk) begin
		if (capture) begin
			act_q   <= cmd.action;
			idx_q   <= EID_W'(cmd.entity_id);
			id_ok_q <= (32'(cmd.entity_id) < ENTITY_IDS);
			pay_q   <= {cmd.pos_x, cmd.pos_y, cmd.vel_x, cmd.vel_y};
			last_q  <= last_nx;
		end
		if (ctrl.commit) begin
			ment_q  <= ent_rd_q;
			freed_q <= sp_slot;
		end
	end

	// Live count and clear address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			clr_addr_q <= '0;
		end else begin
			if (ctrl.commit) count_q <= count_nx;
			if (ctrl.clear_step) clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Response valid: set on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			out_status_q <= res_status;
			out_slot_q   <= FLD_SLOT_W'(res_slot);
			out_moved_q  <= do_move;
			out_ment_q   <= do_move ? FLD_ID_W'(ent_rd_q) : '0;
			out_from_q   <= do_move ? FLD_SLOT_W'(last_q) : '0;
			out_live_q   <= FLD_CNT_W'(count_nx);
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.slot            = out_slot_q;
	assign rsp.moved           = out_moved_q;
	assign rsp.moved_entity    = out_ment_q;
	assign rsp.moved_from_slot = out_from_q;
	assign rsp.live_count      = out_live_q;

endmodule

// ===== design/sparse_set_swap_remove_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_set_swap_remove_unit
// Sparse set of entities packed into dense slots, with swap-remove.
//
// cmd carries one add or remove per transfer; rsp returns one result each.
// An add appends an absent entity at the next free slot with its payload;
// a remove frees the entity's slot and, unless it is the last one, moves
// the last slot's entity and payload into it. Both sides use valid/ready.
// After reset the sparse map is cleared one entry per cycle, all ENTITY_IDS
// entries, with cmd.ready low.
// A command transfer registers the command and the memory reads; the lookup
// state then decides the result and, on commit, registers it for rsp.
// Any command passes through the idle and lookup states; a remove that moves
// an entry adds a move state, which makes the second sparse map write.
// If rsp is stalled, a new command is still taken; its commit waits in the
// lookup step until the response register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_set_swap_remove_unit #(
	parameter int ENTITY_IDS = 1024,
	parameter int CAPACITY   = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	sss_cmd_if.sink   cmd,
	sss_rsp_if.source rsp
);
	import sss_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	sss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	sss_datapath #(
		.ENTITY_IDS (ENTITY_IDS),
		.CAPACITY   (CAPACITY)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// Commit only when the response register can take the result
	`ASSERT_SAME(a_commit_free, clk, arst_n, ctrl.commit, stat.out_free)
	// A move write always follows a commit that needed it
	`ASSERT_NEXT(a_move_follows, clk, arst_n, ctrl.commit && stat.need_move, ctrl.move)
	// One command at a time: busy right after a transfer
	`ASSERT_NEXT(a_busy_after_xfer, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready)
	// Live count never exceeds capacity
	`ASSERT_SAME(a_live_bound, clk, arst_n, rsp.valid, 32'(rsp.live_count) <= CAPACITY)

endmodule

// ===== dv/slot_table_check_pkg.sv =====
// ----------------------------------------------------------------------------
// slot_table_check_pkg
// Tracks occupancy of the sparse set and checks every response against it.
// The scoreboard keeps its own sparse map, dense entity list and live count.
// Each command transfer advances that state and queues the response it must
// produce. Each response transfer is then compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package slot_table_check_pkg;
	import sss_pkg::*;

	localparam int N_IDS      = 1024;
	localparam int N_SLOTS    = 1024;
	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		status_t               status;
		logic [FLD_SLOT_W-1:0] slot;
		logic                  moved;
		logic [FLD_ID_W-1:0]   moved_entity;
		logic [FLD_SLOT_W-1:0] moved_from_slot;
		logic [FLD_CNT_W-1:0]  live_count;
	} slot_result_t;

	class slot_table_scoreboard;
		bit                    live [N_IDS];
		logic [FLD_SLOT_W-1:0] slot_of [N_IDS];
		logic [FLD_ID_W-1:0]   entity_at [N_SLOTS];
		int unsigned           count;
		slot_result_t          pending_results [$];
		int unsigned           failures;
		int unsigned           checked;
		int unsigned           commands;
		int unsigned           swaps;
		int unsigned           peak;
		int unsigned           status_seen [4];

		function new();
			count    = 0;
			failures = 0;
			checked  = 0;
			commands = 0;
			swaps    = 0;
			peak     = 0;
			foreach (live[i]) begin
				live[i]    = 1'b0;
				slot_of[i] = '0;
			end
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		// Apply one accepted command and queue the response it owes
		function void note_command(logic act, logic [FLD_ID_W-1:0] id);
			slot_result_t          r;
			int unsigned           last;
			logic [FLD_SLOT_W-1:0] freed;
			logic [FLD_ID_W-1:0]   mover;
			r = '0;
			commands++;
			if (act == ACT_ADD) begin
				if (live[id]) begin
					r.status = ST_PRESENT;
					r.slot   = slot_of[id];
				end else if (count >= N_SLOTS) begin
					r.status = ST_FULL;
				end else begin
					// append at the first free dense slot
					r.status         = ST_DONE;
					r.slot           = FLD_SLOT_W'(count);
					entity_at[count] = id;
					slot_of[id]      = FLD_SLOT_W'(count);
					live[id]         = 1'b1;
					count++;
				end
			end else if (!live[id]) begin
				r.status = ST_ABSENT;
			end else begin
				freed    = slot_of[id];
				last     = count - 1;
				r.status = ST_DONE;
				r.slot   = freed;
				live[id] = 1'b0;
				slot_of[id] = '0;
				count    = last;
				// pull the last entry down into the hole unless the hole is last
				if (freed < last) begin
					mover             = entity_at[last];
					slot_of[mover]    = freed;
					entity_at[freed]  = mover;
					r.moved           = 1'b1;
					r.moved_entity    = mover;
					r.moved_from_slot = FLD_SLOT_W'(last);
					swaps++;
				end
			end
			r.live_count = FLD_CNT_W'(count);
			if (count > peak)
				peak = count;
			status_seen[r.status]++;
			pending_results = {pending_results, r};
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				failures++;
				if (failures <= SHOW_LIMIT)
					$display("mismatch in %s of response %0d: expected %0d, got %0d",
						name, checked, want, got);
			end
		endfunction

		// Compare one response transfer against the oldest queued response
		function void check_result(slot_result_t got);
			slot_result_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= SHOW_LIMIT)
					$display("response with nothing outstanding: status %0d slot %0d",
						got.status, got.slot);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			check_field("status", 32'(want.status), 32'(got.status));
			check_field("slot", 32'(want.slot), 32'(got.slot));
			check_field("moved", 32'(want.moved), 32'(got.moved));
			check_field("moved_entity", 32'(want.moved_entity), 32'(got.moved_entity));
			check_field("moved_from_slot", 32'(want.moved_from_slot),
				32'(got.moved_from_slot));
			check_field("live_count", 32'(want.live_count), 32'(got.live_count));
		endfunction

		function void report_leftover();
			if (pending_results.size() != 0) begin
				failures += pending_results.size();
				$display("%0d responses never arrived", pending_results.size());
			end
		endfunction
	endclass

endpackage

// ===== dv/tb_sparse_set_swap_remove_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sparse_set_swap_remove_unit
// Self-checking bench for the sparse set swap-remove unit.
// A directed opening walks the empty, present, absent and swap cases; random
// traffic then churns a small id pool, fills the table to capacity, probes
// the full table and drains part of it. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sparse_set_swap_remove_unit;
	import sss_pkg::*;
	import slot_table_check_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MIX_ITEMS   = 280;
	localparam int DRAIN_ITEMS = 80;

	logic                 clk;
	logic                 arst_n;
	bit                   quiet = 1'b0;
	int unsigned          cycle_count = 0;
	int unsigned          sent = 0;
	slot_table_scoreboard sb;
	slot_result_t         seen;

	sss_cmd_if cmd ();
	sss_rsp_if rsp ();

	sparse_set_swap_remove_unit #(
		.ENTITY_IDS (N_IDS),
		.CAPACITY   (N_SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Response side: drop ready for a random stall before each transfer
	initial begin : rsp_sink
		int unsigned stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 3);
			repeat (stall) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
			end
			@(negedge clk);
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
		end
	end

	// Check every response transfer
	always @(posedge clk) begin
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			seen.status          = status_t'(rsp.status);
			seen.slot            = rsp.slot;
			seen.moved           = rsp.moved;
			seen.moved_entity    = rsp.moved_entity;
			seen.moved_from_slot = rsp.moved_from_slot;
			seen.live_count      = rsp.live_count;
			sb.check_result(seen);
		end
	end

	function automatic logic [PAY_W-1:0] random_payload();
		return {$urandom(), $urandom(), $urandom(), $urandom()};
	endfunction

	function automatic logic [FLD_ID_W-1:0] pick_live_entity();
		return sb.entity_at[$urandom_range(0, sb.count - 1)];
	endfunction

	// Scan from a random start for an id not in the set
	function automatic logic [FLD_ID_W-1:0] pick_free_entity();
		int unsigned start;
		int unsigned id;
		start = $urandom_range(0, N_IDS - 1);
		for (int unsigned i = 0; i < N_IDS; i++) begin
			id = (start + i) % N_IDS;
			if (!sb.live[id])
				return FLD_ID_W'(id);
		end
		return FLD_ID_W'(start);
	endfunction

	// Present one command after a random gap and hold it until transfer
	task automatic send_command(input logic act, input logic [FLD_ID_W-1:0] id,
			input logic [PAY_W-1:0] payload);
		int unsigned gap;
		if (sent % 64 == 0)
			quiet = ($urandom_range(0, 3) == 0);
		gap = quiet ? 0 : $urandom_range(0, 3);
		sent++;
		repeat (gap) begin
			@(negedge clk);
			cmd.valid <= 1'b0;
		end
		@(negedge clk);
		cmd.valid     <= 1'b1;
		cmd.action    <= act;
		cmd.entity_id <= id;
		cmd.pos_x     <= payload[31:0];
		cmd.pos_y     <= payload[63:32];
		cmd.vel_x     <= payload[95:64];
		cmd.vel_y     <= payload[127:96];
		do @(posedge clk); while (cmd.ready !== 1'b1);
		sb.note_command(act, id);
	endtask

	// Drop the command and hold off until every result has come
	task automatic wait_for_results();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		logic                act;
		logic [FLD_ID_W-1:0] id;
		sb            = new();
		arst_n        = 1'b0;
		cmd.valid     = 1'b0;
		cmd.action    = ACT_ADD;
		cmd.entity_id = '0;
		cmd.pos_x     = '0;
		cmd.pos_y     = '0;
		cmd.vel_x     = '0;
		cmd.vel_y     = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, duplicates, swap from the end, remove of the last slot
		send_command(ACT_REMOVE, 10'd0, random_payload());
		send_command(ACT_ADD, 10'd0, '0);
		send_command(ACT_ADD, 10'd1023, '1);
		send_command(ACT_ADD, 10'd0, random_payload());
		send_command(ACT_ADD, 10'd512, random_payload());
		send_command(ACT_ADD, 10'h155, random_payload());
		send_command(ACT_ADD, 10'h2AA, random_payload());
		send_command(ACT_REMOVE, 10'd1023, random_payload());
		send_command(ACT_REMOVE, 10'h155, random_payload());
		send_command(ACT_REMOVE, 10'h155, random_payload());
		send_command(ACT_REMOVE, 10'd512, random_payload());
		send_command(ACT_REMOVE, 10'd0, random_payload());
		send_command(ACT_REMOVE, 10'h2AA, random_payload());
		send_command(ACT_REMOVE, 10'h2AA, random_payload());
		send_command(ACT_ADD, 10'd5, '1);
		send_command(ACT_REMOVE, 10'd5, random_payload());

		// Churn a small id pool so hits, misses and swaps are frequent
		for (int i = 0; i < MIX_ITEMS; i++) begin
			act = $urandom_range(0, 1) ? ACT_REMOVE : ACT_ADD;
			if (act == ACT_REMOVE && sb.count != 0 && $urandom_range(0, 3) != 0)
				id = pick_live_entity();
			else if ($urandom_range(0, 9) < 7)
				id = FLD_ID_W'($urandom_range(0, 15));
			else
				id = FLD_ID_W'($urandom());
			send_command(act, id, random_payload());
		end

		// Hold off until the unit has answered everything
		wait_for_results();

		// Fill to capacity, with a few duplicate adds mixed in
		while (sb.count < N_SLOTS) begin
			if (sb.count != 0 && $urandom_range(0, 15) == 0)
				send_command(ACT_ADD, pick_live_entity(), random_payload());
			else
				send_command(ACT_ADD, pick_free_entity(), random_payload());
		end

		// Probe the full table, then free the last and the first slot
		for (int i = 0; i < 6; i++)
			send_command(ACT_ADD, pick_free_entity(), random_payload());
		for (int i = 0; i < 3; i++)
			send_command(ACT_ADD, pick_live_entity(), random_payload());
		send_command(ACT_REMOVE, sb.entity_at[N_SLOTS - 1], random_payload());
		send_command(ACT_ADD, pick_free_entity(), random_payload());
		send_command(ACT_REMOVE, sb.entity_at[0], random_payload());

		// Drain partly while refilling now and then
		for (int i = 0; i < DRAIN_ITEMS; i++) begin
			if (sb.count != 0 && $urandom_range(0, 9) < 7)
				send_command(ACT_REMOVE, pick_live_entity(), random_payload());
			else
				send_command(ACT_ADD, pick_free_entity(), random_payload());
		end

		@(negedge clk);
		cmd.valid <= 1'b0;
		wait_for_results();
		repeat (8) @(posedge clk);
		sb.report_leftover();

		$display("covered %0d commands: %0d done (%0d with swap), %0d already present,",
			sb.commands, sb.status_seen[ST_DONE], sb.swaps, sb.status_seen[ST_PRESENT]);
		$display("%0d not present, %0d table full; peak occupancy %0d of %0d slots",
			sb.status_seen[ST_ABSENT], sb.status_seen[ST_FULL], sb.peak, N_SLOTS);
		if (sb.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
